[sv/rphpd_pkg.sv]
// ----------------------------------------------------------------------------
// rphpd_pkg
// shared types, constants and helpers for the radio packet header parser
// ----------------------------------------------------------------------------
package rphpd_pkg;

    // defaults for top level parameters
    localparam int DEF_MAX_LEN = 64;
    localparam int DEF_QDEPTH  = 2;

    // result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_HDR   = 2'd0;
    localparam t_kind KIND_DATA  = 2'd1;
    localparam t_kind KIND_TRUNC = 2'd2;

    // configuration register map, 8 bytes per register
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam logic [1:0] REG_KEY_LO  = 2'd0;
    localparam logic [1:0] REG_KEY_HI  = 2'd1;
    localparam logic [1:0] REG_SMART   = 2'd2;
    localparam logic [1:0] REG_EXTMASK = 2'd3;

    // header byte positions
    localparam int P_DEST   = 0;
    localparam int P_SRC    = 1;
    localparam int P_HOPSEC = 2;
    localparam int P_NONCE  = 3;
    localparam int P_FUNC   = 4;
    localparam int P_BYTE5  = 5;
    localparam int P_BYTE6  = 6;
    localparam int P_BYTE7  = 7;
    localparam int P_BYTE8  = 8;
    localparam int SIMPLE_ID_POS = 6;
    localparam int EXT_ID_POS    = 9;

    // smart encryption
    localparam int SEC_SMART_BIT = 1;
    localparam int KEY_CYCLE     = 11;
    localparam logic [3:0] K_ID    = 4'd7;
    localparam logic [3:0] K_RA    = 4'd8;
    localparam logic [3:0] K_NONCE = 4'd9;
    localparam logic [3:0] K_SRC   = 4'd10;
    localparam logic [3:0] K_FUNC  = 4'd11;
    localparam logic [3:0] K_LAST  = 4'd11;

    typedef struct packed {
        logic [95:0] key;
        logic        smart_en;
        logic [7:0]  ext_mask;
    } t_cfg;

    // one classified item handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic        last;
        logic        dec;
        logic        ext;
        logic [15:0] dest;
        logic [15:0] src;
        logic [15:0] reg_addr;
        logic [7:0]  reg_id;
        logic [7:0]  func;
        logic [7:0]  hop_sec;
        logic [7:0]  nonce;
        logic [7:0]  data;
        logic [3:0]  key_idx;
    } t_work;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] dest_addr;
        logic [15:0] src_addr;
        logic [15:0] reg_addr;
        logic [7:0]  reg_id;
        logic [7:0]  function_code;
        logic [3:0]  hop_count;
        logic [3:0]  security;
        logic [7:0]  nonce;
        logic        extended;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

    // key byte k of the 12-byte password, zero beyond it
    function automatic logic [7:0] key_byte(input logic [95:0] key, input logic [3:0] k);
        logic [7:0] kb;
        kb = 8'h00;
        if (k <= K_LAST) begin
            kb = key[{k, 3'b000} +: 8];
        end
        return kb;
    endfunction

endpackage

[sv/rphpd_cfg.sv]
// ----------------------------------------------------------------------------
// rphpd_cfg
// configuration registers behind a simple bus port
// ----------------------------------------------------------------------------
module rphpd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rphpd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rphpd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rphpd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output rphpd_pkg::t_cfg                     o_cfg
);
    import rphpd_pkg::*;

    logic [63:0] r_key_lo;
    logic [31:0] r_key_hi;
    logic        r_smart;
    logic [7:0]  r_ext_mask;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo   <= '0;
            r_key_hi   <= '0;
            r_smart    <= 1'b1;
            r_ext_mask <= 8'h80;
        end else if (wr_en) begin
            case (reg_sel)
                REG_KEY_LO:  r_key_lo   <= pwdata;
                REG_KEY_HI:  r_key_hi   <= pwdata[31:0];
                REG_SMART:   r_smart    <= pwdata[0];
                REG_EXTMASK: r_ext_mask <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_KEY_LO:  prdata = r_key_lo;
            REG_KEY_HI:  prdata = {32'h0, r_key_hi};
            REG_SMART:   prdata = {63'h0, r_smart};
            REG_EXTMASK: prdata = {56'h0, r_ext_mask};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.key      = {r_key_hi, r_key_lo};
    assign o_cfg.smart_en = r_smart;
    assign o_cfg.ext_mask = r_ext_mask;

endmodule

[sv/rphpd_front.sv]
// ----------------------------------------------------------------------------
// rphpd_front
// byte position tracking, header capture and item classification
// ----------------------------------------------------------------------------
module rphpd_front #(
    parameter int MAX_LEN = rphpd_pkg::DEF_MAX_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rphpd_pkg::t_cfg    i_cfg,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_last_byte,
    output logic               o_wr,
    output rphpd_pkg::t_work   o_work
);
    import rphpd_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [3:0]       r_kidx,  n_kidx;
    logic             r_dec,   n_dec;
    logic             r_ext,   n_ext;
    logic [15:0]      r_dest,  n_dest;
    logic [15:0]      r_src,   n_src;
    logic [15:0]      r_ra,    n_ra;
    logic [7:0]       r_hs,    n_hs;
    logic [7:0]       r_nonce, n_nonce;
    logic [7:0]       r_fn,    n_fn;

    logic             accept;
    logic             emit;
    logic             ext_now;
    logic [POS_W-1:0] id_pos;
    t_work            work;

    assign accept = i_push && !i_full;
    assign id_pos = r_ext ? POS_W'(EXT_ID_POS) : POS_W'(SIMPLE_ID_POS);
    assign ext_now = |(i_rx_byte & i_cfg.ext_mask);

    always_comb begin
        n_pos   = r_pos;
        n_kidx  = r_kidx;
        n_dec   = r_dec;
        n_ext   = r_ext;
        n_dest  = r_dest;
        n_src   = r_src;
        n_ra    = r_ra;
        n_hs    = r_hs;
        n_nonce = r_nonce;
        n_fn    = r_fn;
        emit    = 1'b0;
        work    = '0;

        if (r_pos > id_pos) begin
            // payload byte, decrypted later in the back end
            emit         = 1'b1;
            work.kind    = KIND_DATA;
            work.data    = i_rx_byte;
            work.dec     = r_dec;
            work.nonce   = r_nonce;
            work.key_idx = r_kidx;
            n_kidx = (r_kidx == 4'(KEY_CYCLE - 1)) ? 4'd0 : r_kidx + 4'd1;
        end else begin
            case (r_pos)
                POS_W'(P_DEST):   n_dest  = {8'h00, i_rx_byte};
                POS_W'(P_SRC):    n_src   = {8'h00, i_rx_byte};
                POS_W'(P_HOPSEC): n_hs    = i_rx_byte;
                POS_W'(P_NONCE):  n_nonce = i_rx_byte;
                POS_W'(P_FUNC): begin
                    n_fn  = i_rx_byte & ~i_cfg.ext_mask;
                    n_ext = ext_now;
                    if (ext_now) begin
                        n_dest = {r_dest[7:0], r_src[7:0]};
                        n_src  = '0;
                    end
                    n_dec = i_cfg.smart_en && !ext_now && r_hs[SEC_SMART_BIT];
                end
                POS_W'(P_BYTE5): begin
                    if (r_ext) begin
                        n_src = {i_rx_byte, 8'h00};
                    end else begin
                        n_ra = {8'h00, i_rx_byte};
                    end
                end
                POS_W'(P_BYTE6): begin
                    if (r_ext) begin
                        n_src = r_src | {8'h00, i_rx_byte};
                    end else begin
                        emit = 1'b1;
                    end
                end
                POS_W'(P_BYTE7): n_ra = {i_rx_byte, 8'h00};
                POS_W'(P_BYTE8): n_ra = {r_ra[15:8], i_rx_byte};
                default:         emit = 1'b1;
            endcase
            if (emit) begin
                work.kind     = KIND_HDR;
                work.dec      = r_dec;
                work.ext      = r_ext;
                work.dest     = r_dest;
                work.src      = r_src;
                work.reg_addr = r_ra;
                work.reg_id   = i_rx_byte;
                work.func     = r_fn;
                work.hop_sec  = r_hs;
                work.nonce    = r_nonce;
            end
        end

        if (i_last_byte) begin
            if (!emit) begin
                work      = '0;
                work.kind = KIND_TRUNC;
                emit      = 1'b1;
            end
            work.last = 1'b1;
            n_pos   = '0;
            n_kidx  = '0;
            n_dec   = 1'b0;
            n_ext   = 1'b0;
            n_dest  = '0;
            n_src   = '0;
            n_ra    = '0;
            n_hs    = '0;
            n_nonce = '0;
            n_fn    = '0;
        end else if (r_pos < POS_W'(MAX_LEN)) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_kidx  <= '0;
            r_dec   <= 1'b0;
            r_ext   <= 1'b0;
            r_dest  <= '0;
            r_src   <= '0;
            r_ra    <= '0;
            r_hs    <= '0;
            r_nonce <= '0;
            r_fn    <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_kidx  <= n_kidx;
            r_dec   <= n_dec;
            r_ext   <= n_ext;
            r_dest  <= n_dest;
            r_src   <= n_src;
            r_ra    <= n_ra;
            r_hs    <= n_hs;
            r_nonce <= n_nonce;
            r_fn    <= n_fn;
        end
    end

    assign o_wr   = accept && emit;
    assign o_work = work;

    a_kidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kidx < 4'(KEY_CYCLE))
        else $error("key index left its cycle");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_LEN))
        else $error("byte position passed its saturation point");

endmodule

[sv/rphpd_queue.sv]
// ----------------------------------------------------------------------------
// rphpd_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module rphpd_queue #(
    parameter int DEPTH = rphpd_pkg::DEF_QDEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  rphpd_pkg::t_work   i_data,
    input  logic               i_rd,
    output rphpd_pkg::t_work   o_data,
    output logic               o_full,
    output logic               o_empty
);
    import rphpd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

[sv/rphpd_back.sv]
// ----------------------------------------------------------------------------
// rphpd_back
// smart decryption and result formatting into the output register
// ----------------------------------------------------------------------------
module rphpd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rphpd_pkg::t_cfg     i_cfg,
    input  logic                i_q_empty,
    input  rphpd_pkg::t_work    i_work,
    output logic                o_q_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output rphpd_pkg::t_result  o_res
);
    import rphpd_pkg::*;

    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic [7:0] nd;
    logic [7:0] pad_fn;
    logic [7:0] pad_src;
    logic [7:0] pad_ra;
    logic [7:0] pad_id;
    logic [7:0] pad_data;
    logic       load;

    assign load   = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_rd = load;

    // plain nonce, then one xor pad per field
    assign nd       = i_work.dec ? (i_work.nonce ^ key_byte(i_cfg.key, K_NONCE)) : i_work.nonce;
    assign pad_fn   = i_work.dec ? (key_byte(i_cfg.key, K_FUNC) ^ nd) : 8'h00;
    assign pad_src  = i_work.dec ? (key_byte(i_cfg.key, K_SRC) ^ nd) : 8'h00;
    assign pad_ra   = i_work.dec ? (key_byte(i_cfg.key, K_RA) ^ nd) : 8'h00;
    assign pad_id   = i_work.dec ? (key_byte(i_cfg.key, K_ID) ^ nd) : 8'h00;
    assign pad_data = i_work.dec ? (key_byte(i_cfg.key, i_work.key_idx) ^ nd) : 8'h00;

    always_comb begin
        res      = '0;
        res.kind = i_work.kind;
        res.last = i_work.last;
        case (i_work.kind)
            KIND_HDR: begin
                res.dest_addr     = i_work.dest;
                res.src_addr      = i_work.src ^ {8'h00, pad_src};
                res.reg_addr      = i_work.reg_addr ^ {8'h00, pad_ra};
                res.reg_id        = i_work.reg_id ^ pad_id;
                res.function_code = i_work.func ^ pad_fn;
                res.hop_count     = i_work.hop_sec[7:4];
                res.security      = i_work.hop_sec[3:0];
                res.nonce         = nd;
                res.extended      = i_work.ext;
            end
            KIND_DATA: res.data_byte = i_work.data ^ pad_data;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == KIND_DATA) |->
            (r_out.src_addr == '0) && (r_out.dest_addr == '0) && (r_out.nonce == '0))
        else $error("payload result carries header fields");

endmodule

[sv/radio_packet_header_parse_decrypt.sv]
// ----------------------------------------------------------------------------
// radio_packet_header_parse_decrypt
// receive-side packet header parser with smart xor decryption
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while full is low, through a queue-style
// port (push/full), and delivers results through a queue-style port
// (empty/pop). The header result appears on the register-id byte (byte 6 in
// simple mode, byte 9 in extended mode), then each later byte gives one
// payload result; a packet that ends before the header is complete gives one
// truncated result. The block sustains one item per cycle while full is low;
// a result is held in an item queue and then in the output register.
// Between front and back sits a small item queue of QUEUE_DEPTH entries, and
// full rises only once that queue and the output register are both occupied.
// Key, enable and flag-mask registers are meant to be written only while no
// packet bytes are in flight.
// ----------------------------------------------------------------------------
module radio_packet_header_parse_decrypt #(
    parameter int MAX_LEN     = rphpd_pkg::DEF_MAX_LEN,
    parameter int QUEUE_DEPTH = rphpd_pkg::DEF_QDEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte stream in
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        i_rx_byte,
    input  logic                              i_last_byte,
    // results out
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        o_kind,
    output logic [15:0]                       o_dest_addr,
    output logic [15:0]                       o_src_addr,
    output logic [15:0]                       o_reg_addr,
    output logic [7:0]                        o_reg_id,
    output logic [7:0]                        o_function_code,
    output logic [3:0]                        o_hop_count,
    output logic [3:0]                        o_security,
    output logic [7:0]                        o_nonce,
    output logic                              o_extended,
    output logic [7:0]                        o_data_byte,
    output logic                              o_last,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rphpd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rphpd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rphpd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import rphpd_pkg::*;

    t_cfg    cfg;
    t_work   wr_work;
    t_work   rd_work;
    t_result res;
    logic    q_wr;
    logic    q_rd;
    logic    q_full;
    logic    q_empty;

    // key and mode registers
    rphpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // front end: tracks position in packet, captures header bytes
    rphpd_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_push      (push),
        .i_full      (q_full),
        .i_rx_byte   (i_rx_byte),
        .i_last_byte (i_last_byte),
        .o_wr        (q_wr),
        .o_work      (wr_work)
    );

    // decouples front from back so each can stall on its own
    rphpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (wr_work),
        .i_rd    (q_rd),
        .o_data  (rd_work),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back end: undoes the xor pads and holds the result for the consumer
    rphpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_work    (rd_work),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    // input stalls only when the item queue is full
    assign full = q_full;

    assign o_kind          = res.kind;
    assign o_dest_addr     = res.dest_addr;
    assign o_src_addr      = res.src_addr;
    assign o_reg_addr      = res.reg_addr;
    assign o_reg_id        = res.reg_id;
    assign o_function_code = res.function_code;
    assign o_hop_count     = res.hop_count;
    assign o_security      = res.security;
    assign o_nonce         = res.nonce;
    assign o_extended      = res.extended;
    assign o_data_byte     = res.data_byte;
    assign o_last          = res.last;

endmodule

[verif/radio_packet_header_parse_decrypt_tb.sv]
// ----------------------------------------------------------------------------
// radio_packet_header_parse_decrypt_tb
// self-checking bench for the radio packet header parser and smart decryption
// ----------------------------------------------------------------------------
// Feeds packet bytes through the push/full port and pops results through the
// empty/pop port, both sides idling at random. A behavioral copy of the parser
// runs beside the block: each accepted byte is parsed there and any result it
// produces is queued, and every popped result is compared field by field with
// the oldest queued one. Key, enable and flag-mask registers are set over the
// APB port between packets, once the block has gone quiet.
// ----------------------------------------------------------------------------
module radio_packet_header_parse_decrypt_tb;
    import rphpd_pkg::*;

    localparam int POS_LIMIT     = DEF_MAX_LEN;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 230;
    localparam int TAIL_ITEMS    = 150;

    // header byte positions
    localparam int POS_DEST   = 0;
    localparam int POS_SRC    = 1;
    localparam int POS_HOPSEC = 2;
    localparam int POS_NONCE  = 3;
    localparam int POS_FUNC   = 4;
    localparam int POS_B5     = 5;
    localparam int POS_B6     = 6;
    localparam int POS_B7     = 7;
    localparam int POS_B8     = 8;
    localparam int ID_SIMPLE  = 6;
    localparam int ID_EXT     = 9;

    // key byte slots used for the header fields
    localparam int KEY_ID    = 7;
    localparam int KEY_RA    = 8;
    localparam int KEY_NONCE = 9;
    localparam int KEY_SRC   = 10;
    localparam int KEY_FUNC  = 11;
    localparam int KEY_WRAP  = 11;
    localparam int SMART_BIT = 1;

    typedef enum int {PKT_GOOD, PKT_SHORT, PKT_NOISE} pkt_shape_e;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_rx_byte;
    logic        i_last_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  o_kind;
    logic [15:0] o_dest_addr;
    logic [15:0] o_src_addr;
    logic [15:0] o_reg_addr;
    logic [7:0]  o_reg_id;
    logic [7:0]  o_function_code;
    logic [3:0]  o_hop_count;
    logic [3:0]  o_security;
    logic [7:0]  o_nonce;
    logic        o_extended;
    logic [7:0]  o_data_byte;
    logic        o_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // register copies
    logic [95:0] key_copy;
    logic        smart_copy;
    logic [7:0]  mask_copy;

    // packet state of the behavioral parser
    int unsigned pos_now;
    logic [3:0]  key_step;
    logic        smart_on_pkt;
    logic        wide_mode;
    logic [15:0] cap_dest;
    logic [15:0] cap_src;
    logic [15:0] cap_reg;
    logic [7:0]  cap_hopsec;
    logic [7:0]  cap_nonce;
    logic [7:0]  cap_func;

    t_result pending_results[$];
    int      fails;
    int      items_sent;
    int      cycles;
    bit      calm;
    bit      hold_req;

    radio_packet_header_parse_decrypt #(
        .MAX_LEN(POS_LIMIT)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_dest_addr    (o_dest_addr),
        .o_src_addr     (o_src_addr),
        .o_reg_addr     (o_reg_addr),
        .o_reg_id       (o_reg_id),
        .o_function_code(o_function_code),
        .o_hop_count    (o_hop_count),
        .o_security     (o_security),
        .o_nonce        (o_nonce),
        .o_extended     (o_extended),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // behavioral parser
    // ------------------------------------------------------------------------

    // password byte k, zero past the twelfth
    function automatic logic [7:0] key_slot(input int k);
        logic [7:0] kb;
        kb = 8'h00;
        if (k < 12) begin
            kb = key_copy[8 * k +: 8];
        end
        return kb;
    endfunction

    function automatic void forget_packet();
        pos_now      = 0;
        key_step     = 4'd0;
        smart_on_pkt = 1'b0;
        wide_mode    = 1'b0;
        cap_dest     = 16'h0;
        cap_src      = 16'h0;
        cap_reg      = 16'h0;
        cap_hopsec   = 8'h0;
        cap_nonce    = 8'h0;
        cap_func     = 8'h0;
    endfunction

    // parse one received byte; returns one when it gives a result
    function automatic bit parse_byte(input logic [7:0] b, input logic lb,
                                      output t_result r);
        int unsigned id_at;
        bit          got;
        bit          header;
        logic [7:0]  nd;
        logic [7:0]  id;
        logic [7:0]  fn;
        logic [15:0] src;
        logic [15:0] ra;
        r      = '0;
        got    = 1'b0;
        header = 1'b0;
        id_at  = wide_mode ? ID_EXT : ID_SIMPLE;
        // nonce in the clear, as the header and payload keys use it
        nd     = smart_on_pkt ? (cap_nonce ^ key_slot(KEY_NONCE)) : cap_nonce;

        if (pos_now > id_at) begin
            // payload byte, key index runs 0..10
            r.kind      = KIND_DATA;
            r.data_byte = smart_on_pkt ? (b ^ key_slot(key_step) ^ nd) : b;
            key_step    = (key_step == KEY_WRAP - 1) ? 4'd0 : key_step + 4'd1;
            got         = 1'b1;
        end else begin
            case (pos_now)
                POS_DEST:   cap_dest   = {8'h00, b};
                POS_SRC:    cap_src    = {8'h00, b};
                POS_HOPSEC: cap_hopsec = b;
                POS_NONCE:  cap_nonce  = b;
                POS_FUNC: begin
                    cap_func  = b & ~mask_copy;
                    wide_mode = (b & mask_copy) != 8'h00;
                    if (wide_mode) begin
                        // the first two bytes form the big-endian destination
                        cap_dest = {cap_dest[7:0], cap_src[7:0]};
                        cap_src  = 16'h0;
                    end
                    smart_on_pkt = smart_copy && !wide_mode && cap_hopsec[SMART_BIT];
                end
                POS_B5: begin
                    if (wide_mode) cap_src = {b, 8'h00};
                    else cap_reg = {8'h00, b};
                end
                POS_B6: begin
                    if (wide_mode) cap_src = cap_src | {8'h00, b};
                    else header = 1'b1;
                end
                POS_B7:  cap_reg = {b, 8'h00};
                POS_B8:  cap_reg = {cap_reg[15:8], b};
                default: header = 1'b1;
            endcase
        end

        if (header) begin
            fn  = cap_func;
            src = cap_src;
            ra  = cap_reg;
            id  = b;
            if (smart_on_pkt) begin
                fn  = fn ^ key_slot(KEY_FUNC) ^ nd;
                src = src ^ {8'h00, key_slot(KEY_SRC) ^ nd};
                ra  = ra ^ {8'h00, key_slot(KEY_RA) ^ nd};
                id  = id ^ key_slot(KEY_ID) ^ nd;
            end
            r.kind          = KIND_HDR;
            r.dest_addr     = cap_dest;
            r.src_addr      = src;
            r.reg_addr      = ra;
            r.reg_id        = id;
            r.function_code = fn;
            r.hop_count     = cap_hopsec[7:4];
            r.security      = cap_hopsec[3:0];
            r.nonce         = nd;
            r.extended      = wide_mode;
            got             = 1'b1;
        end

        if (lb) begin
            // a mark before the header is complete gives a bare truncation item
            if (!got) begin
                r      = '0;
                r.kind = KIND_TRUNC;
                got    = 1'b1;
            end
            r.last = 1'b1;
            forget_packet();
        end else if (pos_now < POS_LIMIT) begin
            pos_now++;
        end
        return got;
    endfunction

    // ------------------------------------------------------------------------
    // result side: pops with random stalls and checks every item
    // ------------------------------------------------------------------------

    function automatic void cmp_field(input string name, input logic [15:0] want,
                                      input logic [15:0] seen);
        if (seen !== want) begin
            $error("%s: expected %h, got %h", name, want, seen);
            fails++;
        end
    endfunction

    initial begin
        t_result want;
        int      hold_left;
        int      stall_left;
        pop        = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error("result item kind %0d with nothing expected", o_kind);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    cmp_field("kind", 16'(want.kind), 16'(o_kind));
                    cmp_field("dest_addr", want.dest_addr, o_dest_addr);
                    cmp_field("src_addr", want.src_addr, o_src_addr);
                    cmp_field("reg_addr", want.reg_addr, o_reg_addr);
                    cmp_field("reg_id", 16'(want.reg_id), 16'(o_reg_id));
                    cmp_field("function_code", 16'(want.function_code),
                              16'(o_function_code));
                    cmp_field("hop_count", 16'(want.hop_count), 16'(o_hop_count));
                    cmp_field("security", 16'(want.security), 16'(o_security));
                    cmp_field("nonce", 16'(want.nonce), 16'(o_nonce));
                    cmp_field("extended", 16'(want.extended), 16'(o_extended));
                    cmp_field("data_byte", 16'(want.data_byte), 16'(o_data_byte));
                    cmp_field("last", 16'(want.last), 16'(o_last));
                end
            end
            // long hold-off on request, else short random stall bursts
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 12);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // byte side and configuration
    // ------------------------------------------------------------------------

    // offer one byte, after an optional idle burst, until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic lb);
        t_result r;
        int      gap;
        gap = 0;
        if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 13);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_rx_byte   <= b;
        i_last_byte <= lb;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (parse_byte(b, lb, r)) pending_results.push_back(r);
        items_sent++;
    endtask

    // fixed byte run, first byte in the top filled byte, mark on the final one
    task automatic send_run(input logic [127:0] bytes, input int count);
        int i;
        for (i = 0; i < count; i++) begin
            send_byte(bytes[8 * (count - 1 - i) +: 8], i == count - 1);
        end
    endtask

    // stop offering and let every expected item drain, plus the pipe latency
    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEY_LO:  key_copy[63:0]  = val;
            REG_KEY_HI:  key_copy[95:64] = val[31:0];
            REG_SMART:   smart_copy      = val[0];
            REG_EXTMASK: mask_copy       = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // register settings per phase: extremes first, then random ones
    task automatic configure(input int which);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] en;
        logic [63:0] mk;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        en = {$urandom, $urandom};
        mk = {$urandom, $urandom};
        case (which)
            0: begin
                lo = '0; hi = '0; en[0] = 1'b1; mk[7:0] = 8'h80;
            end
            1: begin
                lo = '1; hi[31:0] = '1; en[0] = 1'b1; mk[7:0] = 8'hFF;
            end
            2: begin
                en[0] = 1'b0; mk[7:0] = 8'h00;
            end
            3: begin
                en[0] = 1'b1; mk[7:0] = 8'h01;
            end
            4: begin
                // flag bit shares its place with the smart security bit
                en[0] = 1'b1; mk[7:0] = 8'h02;
            end
            default: ;
        endcase
        write_reg(REG_KEY_LO, lo);
        write_reg(REG_KEY_HI, hi);
        write_reg(REG_SMART, en);
        write_reg(REG_EXTMASK, mk);
    endtask

    // one packet: well formed, cut short before the id byte, or random noise
    task automatic send_packet(input pkt_shape_e shape);
        bit         wide;
        int         id_at;
        int         total;
        int         i;
        logic [7:0] b;
        logic       lb;
        wide  = (mask_copy != 8'h00) && ($urandom_range(0, 1) == 1);
        id_at = wide ? ID_EXT : ID_SIMPLE;
        case (shape)
            PKT_GOOD: begin
                // mostly short payloads, now and then one past the position limit
                if ($urandom_range(0, 19) == 0) total = id_at + 1 + $urandom_range(50, 90);
                else total = id_at + 1 + $urandom_range(0, 12);
            end
            PKT_SHORT: total = $urandom_range(1, id_at);
            default:   total = $urandom_range(1, 30);
        endcase
        for (i = 0; i < total; i++) begin
            b  = 8'($urandom_range(0, 255));
            lb = (i == total - 1);
            if (shape == PKT_NOISE) begin
                if ($urandom_range(0, 7) == 0) lb = 1'b1;
            end else begin
                if (i == POS_HOPSEC) b[SMART_BIT] = ($urandom_range(0, 3) != 0);
                if (i == POS_FUNC) begin
                    if (wide) b = b | (mask_copy & (~mask_copy + 8'd1));
                    else b = b & ~mask_copy;
                end
            end
            send_byte(b, lb);
        end
    endtask

    task automatic run_items(input int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) send_packet(PKT_GOOD);
            else if (pick < 18) send_packet(PKT_SHORT);
            else send_packet(PKT_NOISE);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset register values: zero key, smart on, flag in bit 7;
    // simple packet with smart security, one payload byte carrying the mark
    task automatic test_reset_config();
        send_run(128'hFF00_F2A5_7F00_FF3C, 8);
    endtask

    // extended header marked on its id byte, then early ends
    task automatic test_header_forms();
        drain_results();
        write_reg(REG_KEY_LO, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_KEY_HI, 64'h5A5A_0000_FEDC_BA98);
        write_reg(REG_SMART, 64'h1);
        write_reg(REG_EXTMASK, 64'h80);
        send_run(128'h00FF_0F5A_B312_34FF_00C3, 10);
        // mark on the very first byte
        send_run(128'hAB, 1);
        // extended packet ending on byte 5, before its id byte
        send_run(128'h1122_3344_8055, 6);
    endtask

    // with no flag bits every packet is simple, even a function byte of all ones
    task automatic test_empty_mask();
        drain_results();
        write_reg(REG_EXTMASK, 64'h0);
        send_run(128'h0102_FE03_FF04_05, 7);
    endtask

    task automatic test_random_phases();
        int ph;
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_results();
            configure(ph);
            run_items(PHASE_ITEMS);
        end
    endtask

    // receiver holds off while bytes keep coming, so the block fills up
    task automatic test_backpressure();
        hold_req = 1'b1;
        run_items(60);
        drain_results();
    endtask

    // sender stops in the middle of a payload until every item has come back
    task automatic test_sender_pause();
        int         i;
        logic [7:0] b;
        for (i = 0; i < 20; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i == POS_FUNC) b = b & ~mask_copy;
            if (i == 10) drain_results();
            send_byte(b, i == 19);
        end
    endtask

    // last stretch at full rate on both sides
    task automatic test_calm_tail();
        drain_results();
        configure(PHASE_COUNT);
        calm = 1'b1;
        run_items(TAIL_ITEMS);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_rx_byte   = 8'h00;
        i_last_byte = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        fails       = 0;
        items_sent  = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        key_copy    = '0;
        smart_copy  = 1'b1;
        mask_copy   = 8'h80;
        forget_packet();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_header_forms();
        test_empty_mask();
        test_random_phases();
        test_backpressure();
        test_sender_pause();
        test_calm_tail();
        drain_results();

        if (fails == 0) begin
            $display("radio_packet_header_parse_decrypt_tb passed");
        end else begin
            $display("radio_packet_header_parse_decrypt_tb failed");
        end
        $finish;
    end

    // watchdog: a run that stalls ends here
    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("radio_packet_header_parse_decrypt_tb failed");
        $finish;
    end

endmodule
